>>> hdl/usd_pkg.sv
`default_nettype none
// ============================================================================
// usd_pkg
// Shared types, constants and the 7-segment table of the stepped duty block.
// ============================================================================
package usd_pkg;

    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS   = 8'h2D;

    localparam logic [6:0]  DUTY_STEP    = 7'd5;
    localparam logic [6:0]  DUTY_MIN     = 7'd5;
    localparam logic [6:0]  DUTY_MAX     = 7'd95;
    localparam logic [6:0]  DUTY_RESET   = 7'd50;

    localparam logic [15:0] PERIOD_RESET = 16'd49999;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2^23
    localparam int          RECIP_SHIFT  = 30;
    localparam logic [23:0] RECIP_100    = 24'd10737419;

    // byte 0 of the register map
    localparam logic        REG_PWM_PERIOD = 1'b0;

    typedef struct packed {
        logic tick;
        logic plus;
        logic minus;
    } item_t;

    typedef struct packed {
        logic [6:0] duty;
        logic       err;
        logic [6:0] seg;
        logic       high;
    } disp_t;

    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] code;
        case (digit)
            4'h0: code = 7'h3F;
            4'h1: code = 7'h06;
            4'h2: code = 7'h5B;
            4'h3: code = 7'h4F;
            4'h4: code = 7'h66;
            4'h5: code = 7'h6D;
            4'h6: code = 7'h7D;
            4'h7: code = 7'h07;
            4'h8: code = 7'h7F;
            4'h9: code = 7'h6F;
            4'hA: code = 7'h77;
            4'hB: code = 7'h7C;
            4'hC: code = 7'h39;
            4'hD: code = 7'h5E;
            4'hE: code = 7'h79;
            4'hF: code = 7'h71;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

>>> hdl/usd_front.sv
`default_nettype none
// ============================================================================
// usd_front
// Input side: takes stream transfers and decodes them into queue entries.
// ============================================================================
module usd_front (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // rx_byte
    input  wire logic         s_tuser,   // cmd
    input  wire logic         q_full,
    output logic              q_push,
    output usd_pkg::item_t    q_item
);
    import usd_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.tick  = s_tuser;
        q_item.plus  = !s_tuser && (s_tdata == CHAR_PLUS);
        q_item.minus = !s_tuser && (s_tdata == CHAR_MINUS);
    end

endmodule
`default_nettype wire

>>> hdl/usd_queue.sv
`default_nettype none
// ============================================================================
// usd_queue
// Small FIFO of decoded items between the front and back sections.
// ============================================================================
module usd_queue #(
    parameter int DEPTH = usd_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  usd_pkg::item_t    push_item,
    output logic              full,
    input  wire logic         pop,
    output usd_pkg::item_t    pop_item,
    output logic              empty
);
    import usd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    item_t          mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> hdl/usd_back.sv
`default_nettype none
// ============================================================================
// usd_back
// Execution side: duty and display state, compare scaling, output register.
// ============================================================================
module usd_back (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [15:0]  pwm_period,
    input  usd_pkg::item_t    q_item,
    input  wire logic         q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata
);
    import usd_pkg::*;

    logic           adv;

    logic [6:0]     duty_reg, duty_next;
    logic           show_high_next_reg, show_high_next_next;
    logic [6:0]     shown_pattern_reg, shown_pattern_next;
    logic           shown_high_reg, shown_high_next;
    logic           err;

    logic [14:0]    tens_prod;
    logic [3:0]     tens, units;
    logic [6:0]     tens_x10;

    logic           s1_valid_reg;
    disp_t          s1_reg;
    logic           s2_valid_reg;
    disp_t          s2_reg;
    logic [23:0]    s2_prod_reg;
    logic [47:0]    quot_prod;

    logic           out_valid_reg;
    disp_t          out_reg;
    logic [16:0]    out_cmp_reg;

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    assign tens_prod = 15'(duty_reg) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    assign units     = 4'(duty_reg - tens_x10);

    always_comb begin
        duty_next           = duty_reg;
        show_high_next_next = show_high_next_reg;
        shown_pattern_next  = shown_pattern_reg;
        shown_high_next     = shown_high_reg;
        err                 = 1'b0;
        if (q_item.tick) begin
            shown_pattern_next  = show_high_next_reg ? seg_code(tens) : seg_code(units);
            shown_high_next     = show_high_next_reg;
            show_high_next_next = !show_high_next_reg;
        end else if (q_item.plus) begin
            if (duty_reg >= DUTY_MAX) begin
                err = 1'b1;
            end else begin
                duty_next = duty_reg + DUTY_STEP;
            end
        end else if (q_item.minus) begin
            if (duty_reg <= DUTY_MIN) begin
                err = 1'b1;
            end else begin
                duty_next = duty_reg - DUTY_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg           <= DUTY_RESET;
            show_high_next_reg <= 1'b1;
            shown_pattern_reg  <= '0;
            shown_high_reg     <= 1'b0;
        end else if (q_pop) begin
            duty_reg           <= duty_next;
            show_high_next_reg <= show_high_next_next;
            shown_pattern_reg  <= shown_pattern_next;
            shown_high_reg     <= shown_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign quot_prod = 48'(s2_prod_reg) * 48'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg.duty <= duty_next;
            s1_reg.err  <= err;
            s1_reg.seg  <= shown_pattern_next;
            s1_reg.high <= shown_high_next;
            s2_reg      <= s1_reg;
            s2_prod_reg <= 24'(17'(pwm_period) + 17'd1) * 24'(s1_reg.duty);
            out_reg     <= s2_reg;
            out_cmp_reg <= quot_prod[RECIP_SHIFT +: 17];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.high, out_reg.seg, out_reg.err,
                       out_cmp_reg, out_reg.duty};

endmodule
`default_nettype wire

>>> hdl/uart_stepped_duty_with_bcd_display.sv
`default_nettype none
// ============================================================================
// uart_stepped_duty_with_bcd_display
// Stepped PWM duty control from serial commands with a two-digit display.
// ----------------------------------------------------------------------------
// Input stream: s_tuser = 0 carries a received byte in s_tdata ('+' raises
// the duty by 5, '-' lowers it by 5, within 5..95, others change nothing);
// s_tuser = 1 is a display tick that drives the next digit, tens first.
// Every input transfer yields exactly one output transfer carrying the
// duty, the compare value (period+1)*duty/100, the range error flag and
// the currently driven segment code and digit select.
// Throughput is one transfer per cycle unless m_tready stalls the output.
// The transfer writes the queue; the popped entry then passes the state
// update into s1, the period multiply into s2, and the reciprocal multiply
// that divides by 100 into the output register.
// A two-entry queue decouples input from the execution pipeline; when
// m_tready is low the pipeline holds, the queue fills and s_tready drops.
// Reset sets duty 50, period 49999, a blank display with the tens digit
// next, and empties the queue and pipeline. APB writes at byte 0 set the
// period and must be made only while the block is idle (not enforced).
// ============================================================================
module uart_stepped_duty_with_bcd_display #(
    parameter int QUEUE_DEPTH = usd_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  wire logic         s_tuser,   // [0] cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [6:0] duty_percent, [23:7] pwm_compare, [24] range_error,
    // [31:25] segment_pattern, [32] digit_high_on, [39:33] zero
    output logic [39:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import usd_pkg::*;

    logic [15:0]  pwm_period_reg;
    logic         q_push, q_pop, q_full, q_empty;
    item_t        push_item, pop_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PWM_PERIOD) ? {16'b0, pwm_period_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PWM_PERIOD) begin
            pwm_period_reg <= pwdata[15:0];
        end
    end

    usd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    usd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pwm_period (pwm_period_reg),
        .q_item     (pop_item),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

>>> hdl/usd_checker.sv
`default_nettype none
// ============================================================================
// usd_checker
// Port-level checks of the stepped duty block, bound to the top level.
// ============================================================================
module usd_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] >= 7'd5 && m_tdata[6:0] <= 7'd95 && m_tdata[39:33] == '0)
        else $error("duty out of range or padding set");

    a_err_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> m_tdata[6:0] == 7'd5 || m_tdata[6:0] == 7'd95)
        else $error("range error away from a limit");

    a_blank_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:25] == 7'd0 |-> !m_tdata[32])
        else $error("tens digit selected with blank pattern");

endmodule

bind uart_stepped_duty_with_bcd_display usd_checker u_usd_checker (.*);
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the stepped PWM duty block with two-digit display.
// ----------------------------------------------------------------------------
// A queue of serial bytes and display ticks feeds a stream driver. A monitor
// predicts each reading (duty, compare value, range flag, segment code and
// digit select) as the input transfer is taken, and checks every output
// transfer field by field. Phases walk the period register through its
// extremes and switch sender gaps and receiver stalls.
// ============================================================================
module tb;

    import usd_pkg::*;

    localparam logic       CMD_RX_BYTE   = 1'b0;
    localparam logic       CMD_TICK      = 1'b1;
    localparam logic [2:0] PERIOD_ADDR   = 3'd0;
    localparam logic [2:0] UNUSED_ADDR   = 3'd4;
    localparam int         PERCENT_SCALE = 100;
    localparam int         DRAIN_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         PHASE_ITEMS   = 178;
    localparam int         MAX_PRINTED   = 100;

    // segment codes for digits 0..F, digit 0 in the low bits
    localparam logic [16*7-1:0] SEG_CODES = {
        7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
        7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct {
        logic       cmd;
        logic [7:0] rx_byte;
    } serial_item_t;

    typedef struct {
        logic [6:0]  duty_percent;
        logic [16:0] pwm_compare;
        logic        range_error;
        logic [6:0]  segment_pattern;
        logic        digit_high_on;
    } duty_reading_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] rx_byte
    logic        s_tuser  = 1'b0;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [6:0] duty_percent, [23:7] pwm_compare, [24] range_error,
    // [31:25] segment_pattern, [32] digit_high_on, [39:33] zero
    logic [39:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    serial_item_t  serial_todo[$];
    duty_reading_t readings_due[$];
    serial_item_t  next_item;
    duty_reading_t want_reading;

    logic        rx_taken = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned reading_index = 0;

    // predictor state
    logic [15:0] period_now;
    logic [6:0]  duty_now;
    logic        tens_next;
    logic [6:0]  seg_now;
    logic        high_now;

    uart_stepped_duty_with_bcd_display dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("reading %0d %s: got %0h, want %0h",
                                      reading_index, fname, got, want));
        end
    endtask

    function automatic duty_reading_t step_duty_display(logic cmd, logic [7:0] rx_byte);
        duty_reading_t    r;
        logic [3:0]       digit;
        longint unsigned  scaled;
        r.range_error = 1'b0;
        if (cmd == CMD_RX_BYTE) begin
            if (rx_byte == CHAR_PLUS) begin
                if (duty_now >= DUTY_MAX) r.range_error = 1'b1;
                else duty_now = duty_now + DUTY_STEP;
            end else if (rx_byte == CHAR_MINUS) begin
                if (duty_now <= DUTY_MIN) r.range_error = 1'b1;
                else duty_now = duty_now - DUTY_STEP;
            end
        end else begin
            if (tens_next) begin
                digit    = 4'(duty_now / 10);
                high_now = 1'b1;
            end else begin
                digit    = 4'(duty_now % 10);
                high_now = 1'b0;
            end
            seg_now   = SEG_CODES[digit*7 +: 7];
            tens_next = !tens_next;
        end
        scaled = ((64'(period_now) + 64'd1) * 64'(duty_now)) / 64'(PERCENT_SCALE);
        r.duty_percent    = duty_now;
        r.pwm_compare     = scaled[16:0];
        r.segment_pattern = seg_now;
        r.digit_high_on   = high_now;
        return r;
    endfunction

    // stream driver
    always @(negedge aclk) begin
        if (!s_tvalid || rx_taken) begin
            if (aresetn && serial_todo.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                next_item = serial_todo.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.cmd;
                s_tdata  <= next_item.rx_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and checker
    always @(posedge aclk) begin
        rx_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (readings_due.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, data %0h", m_tdata));
            end else begin
                want_reading = readings_due.pop_front();
                check_field("duty_percent", m_tdata[6:0], want_reading.duty_percent);
                check_field("pwm_compare", m_tdata[23:7], want_reading.pwm_compare);
                check_field("range_error", m_tdata[24], want_reading.range_error);
                check_field("segment_pattern", m_tdata[31:25],
                            want_reading.segment_pattern);
                check_field("digit_high_on", m_tdata[32], want_reading.digit_high_on);
                check_field("pad", m_tdata[39:33], 32'd0);
            end
            reading_index++;
        end
        if (aresetn && s_tvalid && s_tready) begin
            readings_due.push_back(step_duty_display(s_tuser, s_tdata));
        end
    end

    task automatic push_item(logic cmd, logic [7:0] rx_byte);
        serial_item_t it;
        it.cmd     = cmd;
        it.rx_byte = rx_byte;
        serial_todo.push_back(it);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == PERIOD_ADDR) period_now = data[15:0];
    endtask

    task automatic wait_idle();
        int unsigned spins = 0;
        while (serial_todo.size() != 0 || s_tvalid) @(posedge aclk);
        while (readings_due.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        while (readings_due.size() != 0) begin
            want_reading = readings_due.pop_front();
            report_mismatch($sformatf("missing reading, duty %0d",
                                      want_reading.duty_percent));
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // runs of '+' or '-' with ticks mixed in, tick bursts, and raw noise bytes
    task automatic fill_random(int unsigned count);
        int unsigned n = 0;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  step_char;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                step_char = (pick < 40) ? CHAR_PLUS : CHAR_MINUS;
                len = $urandom_range(20, 1);
                repeat (len) begin
                    push_item(CMD_RX_BYTE, step_char);
                    n++;
                    if ($urandom_range(4) == 0) begin
                        push_item(CMD_TICK, 8'($urandom_range(255)));
                        n++;
                    end
                end
            end else if (pick < 90) begin
                len = $urandom_range(4, 1);
                repeat (len) begin
                    push_item(CMD_TICK, 8'($urandom_range(255)));
                    n++;
                end
            end else begin
                push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
                n++;
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("** uart_stepped_duty_with_bcd_display: FAILED **");
        $finish;
    end

    initial begin
        logic [15:0] periods [8];
        int unsigned mode;
        periods = '{16'd0, 16'hFFFF, 16'd1, 16'd99, 16'($urandom_range(65535)),
                    16'hFFFE, 16'($urandom_range(65535)), PERIOD_RESET};

        period_now = PERIOD_RESET;
        duty_now   = DUTY_RESET;
        tens_next  = 1'b1;
        seg_now    = 7'd0;
        high_now   = 1'b0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: other bytes, blank display, ticks, upper limit, way down
        push_item(CMD_RX_BYTE, 8'h00);
        push_item(CMD_RX_BYTE, 8'hFF);
        push_item(CMD_RX_BYTE, 8'h2C);
        push_item(CMD_TICK, 8'hFF);
        push_item(CMD_TICK, CHAR_PLUS);
        repeat (9) push_item(CMD_RX_BYTE, CHAR_PLUS);
        push_item(CMD_RX_BYTE, CHAR_PLUS);
        push_item(CMD_TICK, CHAR_MINUS);
        push_item(CMD_TICK, 8'h00);
        repeat (8) push_item(CMD_RX_BYTE, CHAR_MINUS);
        wait_idle();

        // write to an unmapped register must not disturb the period
        apb_write(UNUSED_ADDR, $urandom());

        for (int p = 0; p < 8; p++) begin
            apb_write(PERIOD_ADDR, {16'($urandom_range(65535)), periods[p]});
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 25 : 0;
            recv_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 25 : 0;
            fill_random(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("** uart_stepped_duty_with_bcd_display: PASSED **");
        end else begin
            $display("** uart_stepped_duty_with_bcd_display: FAILED **");
        end
        $finish;
    end

endmodule

>>> uart_stepped_duty_with_bcd_display.f
hdl/usd_pkg.sv
hdl/usd_front.sv
hdl/usd_queue.sv
hdl/usd_back.sv
hdl/uart_stepped_duty_with_bcd_display.sv
hdl/usd_checker.sv
test/tb.sv
